[hw/rtl/dmam_pkg.sv]
`timescale 1ns / 1ps

package dmam_pkg;

    // Widths of the pixel fields and of the configuration port.
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned DEPTH_W     = 16;
    localparam int unsigned THRESH_W    = 17;
    localparam int unsigned FRAME_PIX_W = 20;
    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned CFG_IDX_W   = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_ACTIVE       = 2'd1,
        REG_FRAME_PIXELS = 2'd2
    } t_cfg_reg;

    // Reset values of the configuration registers.
    localparam logic [THRESH_W-1:0]    THRESHOLD_RST    = '0;
    localparam logic                   ACTIVE_RST       = 1'b1;
    localparam logic [FRAME_PIX_W-1:0] FRAME_PIXELS_RST = 20'd524288;

endpackage

[hw/rtl/depth_motion_alpha_mask_unit.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------------
// pixel in  | input     | i_valid / o_ready  | i_red, i_green, i_blue, i_alpha
// pixel out | output    | o_valid / i_ready  | o_red_out, o_green_out, o_blue_out, o_alpha_out
// config    | input     | i_cfg_wr_en        | i_cfg_index, i_cfg_wdata
//
// One pixel is taken every cycle while the output is not stalled and the clearing pass is over;
// its result is offered once it has passed the input and the output register.
// The rate is set by the single port of the depth store, which does one read-first
// read-modify-write access per pixel.
// After reset the depth store is cleared one entry a cycle, all MAX_PIXELS entries, with o_ready low.
// A stalled output holds its beat; input keeps flowing until both stages are full.

module depth_motion_alpha_mask_unit #(
    parameter int unsigned MAX_PIXELS = 524288
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [dmam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmam_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Pixel input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dmam_pkg::CHAN_W-1:0]       i_red,
    input  logic [dmam_pkg::CHAN_W-1:0]       i_green,
    input  logic [dmam_pkg::CHAN_W-1:0]       i_blue,
    input  logic [dmam_pkg::CHAN_W-1:0]       i_alpha,
    // Pixel output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dmam_pkg::CHAN_W-1:0]       o_red_out,
    output logic [dmam_pkg::CHAN_W-1:0]       o_green_out,
    output logic [dmam_pkg::CHAN_W-1:0]       o_blue_out,
    output logic [dmam_pkg::CHAN_W-1:0]       o_alpha_out
);

    localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned CNT_W  = ADDR_W + 1;
    localparam int unsigned SZ_W   = (CNT_W > dmam_pkg::FRAME_PIX_W) ?
                                     CNT_W : dmam_pkg::FRAME_PIX_W;
    localparam logic [SZ_W-1:0]   MAX_SZ   = SZ_W'(MAX_PIXELS);
    localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAX_PIXELS - 1);

    // Configuration registers
    logic [dmam_pkg::THRESH_W-1:0]    r_threshold;
    logic                             r_active;
    logic [dmam_pkg::FRAME_PIX_W-1:0] r_frame_pixels;

    // Position and clearing pass
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    // Depth store
    logic [dmam_pkg::DEPTH_W-1:0] mem_depth [MAX_PIXELS];
    logic [dmam_pkg::DEPTH_W-1:0] r_prev_depth;

    // Stage one: pixel beside its stored depth
    logic                         r_s1_valid;
    logic                         r_s1_active;
    logic [dmam_pkg::CHAN_W-1:0]  r_s1_red;
    logic [dmam_pkg::CHAN_W-1:0]  r_s1_green;
    logic [dmam_pkg::CHAN_W-1:0]  r_s1_blue;
    logic [dmam_pkg::CHAN_W-1:0]  r_s1_alpha;

    // Output register
    logic                         r_o_valid;
    logic [dmam_pkg::CHAN_W-1:0]  r_o_red;
    logic [dmam_pkg::CHAN_W-1:0]  r_o_green;
    logic [dmam_pkg::CHAN_W-1:0]  r_o_blue;
    logic [dmam_pkg::CHAN_W-1:0]  r_o_alpha;

    logic                         w_out_free;
    logic                         w_accept;
    logic [SZ_W-1:0]              w_size;
    logic [SZ_W-1:0]              w_fp_ext;
    logic [ADDR_W-1:0]            w_pos;
    logic                         w_mem_we;
    logic [ADDR_W-1:0]            w_mem_addr;
    logic [dmam_pkg::DEPTH_W-1:0] w_mem_wdata;
    logic [dmam_pkg::DEPTH_W-1:0] w_s1_depth;
    logic [dmam_pkg::DEPTH_W-1:0] w_diff;
    logic [dmam_pkg::CHAN_W-1:0]  n_alpha;

    // Handshake
    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = !r_clearing && (!r_s1_valid || w_out_free);
    assign w_accept   = i_valid && o_ready;

    // Effective frame size and the position this pixel uses.
    always_comb begin
        w_fp_ext = SZ_W'(r_frame_pixels);
        if (w_fp_ext == '0) begin
            w_size = SZ_W'(1);
        end else if (w_fp_ext > MAX_SZ) begin
            w_size = MAX_SZ;
        end else begin
            w_size = w_fp_ext;
        end
        w_pos = (SZ_W'(r_pos) < w_size) ? r_pos : '0;
        n_pos = ((SZ_W'(w_pos) + SZ_W'(1)) >= w_size) ? '0 : w_pos + ADDR_W'(1);
    end

    // Store access: the clearing pass owns the port until it ends.
    always_comb begin
        if (r_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = r_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_accept && r_active;
            w_mem_addr  = w_pos;
            w_mem_wdata = {i_red, i_green};
        end
    end

    // Read-first store: the old depth comes out as the new one goes in.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_depth[w_mem_addr] <= w_mem_wdata;
        end
        if (w_accept) begin
            r_prev_depth <= mem_depth[w_mem_addr];
        end
    end

    // Configuration registers, position and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= dmam_pkg::THRESHOLD_RST;
            r_active       <= dmam_pkg::ACTIVE_RST;
            r_frame_pixels <= dmam_pkg::FRAME_PIXELS_RST;
            r_pos          <= '0;
            r_clr_addr     <= '0;
            r_clearing     <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    dmam_pkg::REG_THRESHOLD:
                        r_threshold <= i_cfg_wdata[dmam_pkg::THRESH_W-1:0];
                    dmam_pkg::REG_ACTIVE:
                        r_active <= i_cfg_wdata[0];
                    dmam_pkg::REG_FRAME_PIXELS:
                        r_frame_pixels <= i_cfg_wdata[dmam_pkg::FRAME_PIX_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADR) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (w_accept && r_active) begin
                r_pos <= n_pos;
            end
        end
    end

    // Stage one control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || w_out_free) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_active <= r_active;
            r_s1_red    <= i_red;
            r_s1_green  <= i_green;
            r_s1_blue   <= i_blue;
            r_s1_alpha  <= i_alpha;
        end
    end

    // Masking decision: noise when either depth is zero, still when the change is small.
    always_comb begin
        w_s1_depth = {r_s1_red, r_s1_green};
        w_diff     = (w_s1_depth >= r_prev_depth) ? w_s1_depth - r_prev_depth
                                                  : r_prev_depth - w_s1_depth;
        n_alpha    = r_s1_alpha;
        if (r_s1_active && r_s1_alpha != '0) begin
            if (w_s1_depth == '0 || r_prev_depth == '0) begin
                n_alpha = '0;
            end else if ({1'b0, w_diff} < r_threshold) begin
                n_alpha = '0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_o_red   <= r_s1_red;
            r_o_green <= r_s1_green;
            r_o_blue  <= r_s1_blue;
            r_o_alpha <= n_alpha;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red_out   = r_o_red;
    assign o_green_out = r_o_green;
    assign o_blue_out  = r_o_blue;
    assign o_alpha_out = r_o_alpha;

endmodule

[hw/rtl/dmam_checker.sv]
`timescale 1ns / 1ps

module dmam_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_wr_en,
    input logic [dmam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [dmam_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [dmam_pkg::CHAN_W-1:0]       o_red_out,
    input logic [dmam_pkg::CHAN_W-1:0]       o_green_out,
    input logic [dmam_pkg::CHAN_W-1:0]       o_alpha_out
);

    logic       r_active;
    logic [1:0] r_inflight;

    // Filtering mode as last written on the port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= dmam_pkg::ACTIVE_RST;
        end else if (i_cfg_wr_en && i_cfg_index == dmam_pkg::REG_ACTIVE) begin
            r_active <= i_cfg_wdata[0];
        end
    end

    // Beats taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end

    // The store clearing pass keeps input closed straight after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input opened while the depth store is being cleared");

    // No result beat without an accepted pixel behind it, and at most two held.
    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || r_inflight != 2'd0) && r_inflight != 2'd3)
        else $error("result beat count does not match accepted pixels");

    // A pixel that leaves with nonzero alpha while filtering must carry a nonzero depth.
    a_noise_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_active && o_alpha_out != '0) |-> (o_red_out != '0 || o_green_out != '0))
        else $error("zero-depth pixel passed with nonzero alpha");

    // A stalled result beat holds its alpha.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_alpha_out)))
        else $error("result beat changed while stalled");

endmodule

bind depth_motion_alpha_mask_unit dmam_checker u_dmam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_cfg_index (i_cfg_index),
    .i_cfg_wdata (i_cfg_wdata),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_alpha_out (o_alpha_out)
);
